@@ hdl/trc_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-rotor cipher package
// Operation codes, rotor numbering, register indexes, step thresholds and
// fixed field widths shared by the cipher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

    localparam int OP_W        = 2;
    localparam int SEL_W       = 2;
    localparam int SYMBOL_W    = 5;
    localparam int KEY_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int COUNT_W     = 4;

    localparam int SYMBOL_CODES = 1 << SYMBOL_W;

    localparam int ROTORS       = 3;
    localparam int ROTOR_FIRST  = 0;
    localparam int ROTOR_SECOND = 1;
    localparam int ROTOR_THIRD  = 2;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THIRD  = 2'd2;

    localparam logic [COUNT_W-1:0] STEP_THIRD_AT  = 4'd4;
    localparam logic [COUNT_W-1:0] STEP_SECOND_AT = 4'd8;
    localparam logic [COUNT_W-1:0] STEP_FIRST_AT  = 4'd12;

endpackage

`default_nettype wire

@@ hdl/three_rotor_cipher.sv @@
// ----------------------------------------------------------------------------
// Three-rotor cipher
// Rotor substitution cipher without a reflector on symbol indices.
//
// The input channel (in_valid, in_stall) carries one beat per item: a rotor
// load, an encrypt or a decrypt. Loads give no result; in-range ones write
// one entry of a rotor and of its inverse. Each encrypt or decrypt beat gives
// one beat on the output channel (out_valid, out_stall) with result_symbol.
// A beat is taken into the input register and substituted in the following
// cycle through three rotor register-file lookups; the result register takes
// it when the input register advances. One item is accepted every cycle; the
// three chained lookups with their modular adjustments set the clock. While
// the receiver stalls, the result register holds its beat and the input
// register still takes beats; loads pass on, but the next encrypt or decrypt
// beat waits there and further input stalls. Keys are written through
// cfg_write, cfg_index and cfg_data, by the user only while idle; the block
// does not enforce it. Reset clears the keys, the offsets, the symbol count
// and both channels; rotor tables hold no defined contents until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module three_rotor_cipher #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [trc_pkg::OP_W-1:0]       operation,
    input  wire logic [trc_pkg::SEL_W-1:0]      rotor_select,
    input  wire logic [trc_pkg::SYMBOL_W-1:0]   entry_index,
    input  wire logic [trc_pkg::SYMBOL_W-1:0]   entry_value,
    input  wire logic [trc_pkg::SYMBOL_W-1:0]   symbol,
    input  wire logic                           first_of_message,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [trc_pkg::SYMBOL_W-1:0]   result_symbol,
    input  wire logic                           cfg_write,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trc_pkg::KEY_W-1:0]      cfg_data
);

    import trc_pkg::*;

    localparam int SYM_W = $clog2(ALPHABET_SIZE);

    logic [KEY_W-1:0]    key_reg [ROTORS];
    logic [SYM_W-1:0]    key_red [ROTORS];
    logic [SYM_W-1:0]    mod_tab [SYMBOL_CODES];

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [OP_W-1:0]     s1_op_reg;
    logic [SEL_W-1:0]    s1_sel_reg;
    logic [SYMBOL_W-1:0] s1_index_reg;
    logic [SYMBOL_W-1:0] s1_value_reg;
    logic [SYMBOL_W-1:0] s1_symbol_reg;
    logic                s1_first_reg;

    logic                in_fire;
    logic                s1_has_result;
    logic                s1_adv;
    logic                load_ok;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SYMBOL_W-1:0] result_reg;
    logic [SYMBOL_W-1:0] result_next;

    logic [SYM_W-1:0]    offset   [ROTORS];
    logic [SYM_W-1:0]    fwd_addr [ROTORS];
    logic [SYM_W-1:0]    fwd_data [ROTORS];
    logic [SYM_W-1:0]    inv_addr [ROTORS];
    logic [SYM_W-1:0]    inv_data [ROTORS];
    logic [SYM_W-1:0]    sym_red;
    logic [SYM_W-1:0]    enc_sym;
    logic [SYM_W-1:0]    dec_sym;

    function automatic logic [SYM_W-1:0] sub_mod(input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b);
        logic [SYM_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[SYM_W])
            d = d + (SYM_W+1)'(ALPHABET_SIZE);
        return d[SYM_W-1:0];
    endfunction

    function automatic logic [SYM_W-1:0] add_mod(input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b);
        logic [SYM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SYM_W+1)'(ALPHABET_SIZE))
            s = s - (SYM_W+1)'(ALPHABET_SIZE);
        return s[SYM_W-1:0];
    endfunction

    for (genvar g = 0; g < SYMBOL_CODES; g++)
    begin : g_mod
        assign mod_tab[g] = SYM_W'(g % ALPHABET_SIZE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROTORS; r++)
                key_reg[r] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_FIRST:  key_reg[ROTOR_FIRST]  <= cfg_data;
                CFG_KEY_SECOND: key_reg[ROTOR_SECOND] <= cfg_data;
                CFG_KEY_THIRD:  key_reg[ROTOR_THIRD]  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < ROTORS; r++)
            key_red[r] = mod_tab[key_reg[r]];
    end

    assign s1_has_result = (s1_op_reg == OP_ENCRYPT) || (s1_op_reg == OP_DECRYPT);
    assign s1_adv   = s1_valid_reg && (!s1_has_result || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;
    assign s1_valid_next = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= operation;
            s1_sel_reg    <= rotor_select;
            s1_index_reg  <= entry_index;
            s1_value_reg  <= entry_value;
            s1_symbol_reg <= symbol;
            s1_first_reg  <= first_of_message;
        end
    end

    assign load_ok = s1_adv && (s1_op_reg == OP_LOAD)
                     && (32'(s1_index_reg) < ALPHABET_SIZE)
                     && (32'(s1_value_reg) < ALPHABET_SIZE);

    trc_stepper #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .SYM_W         (SYM_W)
    ) u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_adv && s1_has_result),
        .restart (s1_first_reg),
        .key     (key_red),
        .offset  (offset)
    );

    for (genvar r = 0; r < ROTORS; r++)
    begin : g_rotor
        trc_rotor #(
            .ALPHABET_SIZE (ALPHABET_SIZE),
            .SYM_W         (SYM_W)
        ) u_rotor (
            .clk      (clk),
            .wr_en    (load_ok && (s1_sel_reg == SEL_W'(r))),
            .wr_index (SYM_W'(s1_index_reg)),
            .wr_value (SYM_W'(s1_value_reg)),
            .fwd_addr (fwd_addr[r]),
            .fwd_data (fwd_data[r]),
            .inv_addr (inv_addr[r]),
            .inv_data (inv_data[r])
        );
    end

    assign sym_red = mod_tab[s1_symbol_reg];

    assign fwd_addr[ROTOR_THIRD]  = sub_mod(sym_red, offset[ROTOR_THIRD]);
    assign fwd_addr[ROTOR_SECOND] = sub_mod(fwd_data[ROTOR_THIRD], offset[ROTOR_SECOND]);
    assign fwd_addr[ROTOR_FIRST]  = sub_mod(fwd_data[ROTOR_SECOND], offset[ROTOR_FIRST]);
    assign enc_sym = fwd_data[ROTOR_FIRST];

    assign inv_addr[ROTOR_FIRST]  = sym_red;
    assign inv_addr[ROTOR_SECOND] = add_mod(inv_data[ROTOR_FIRST], offset[ROTOR_FIRST]);
    assign inv_addr[ROTOR_THIRD]  = add_mod(inv_data[ROTOR_SECOND], offset[ROTOR_SECOND]);
    assign dec_sym = add_mod(inv_data[ROTOR_THIRD], offset[ROTOR_THIRD]);

    assign result_next = (s1_op_reg == OP_ENCRYPT) ? SYMBOL_W'(enc_sym) : SYMBOL_W'(dec_sym);

    always_comb
    begin
        if (s1_adv && s1_has_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has_result)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign result_symbol = result_reg;

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted beat did not reach the input register");

    a_blocked_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_has_result && out_valid_reg && out_stall |=> s1_valid_reg)
        else $error("symbol beat dropped while the result register was full");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_has_result && !(out_valid_reg && out_stall) |=> !out_valid_reg)
        else $error("non-symbol beat produced a result");

endmodule

`default_nettype wire

@@ hdl/trc_rotor.sv @@
// ----------------------------------------------------------------------------
// Rotor table
// Forward permutation and its inverse as register files, written together
// by a load and read combinationally at one address each.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_rotor #(
    parameter int ALPHABET_SIZE = 26,
    parameter int SYM_W         = 5
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [SYM_W-1:0] wr_index,
    input  wire logic [SYM_W-1:0] wr_value,
    input  wire logic [SYM_W-1:0] fwd_addr,
    output logic      [SYM_W-1:0] fwd_data,
    input  wire logic [SYM_W-1:0] inv_addr,
    output logic      [SYM_W-1:0] inv_data
);

    logic [SYM_W-1:0] fwd_mem [ALPHABET_SIZE];
    logic [SYM_W-1:0] inv_mem [ALPHABET_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_mem[wr_index] <= wr_value;
            inv_mem[wr_value] <= wr_index;
        end
    end

    assign fwd_data = fwd_mem[fwd_addr];
    assign inv_data = inv_mem[inv_addr];

endmodule

`default_nettype wire

@@ hdl/trc_stepper.sv @@
// ----------------------------------------------------------------------------
// Rotor stepper
// Holds the symbol count and the three rotor offsets, and gives the offsets
// that apply to the symbol now being substituted.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_stepper #(
    parameter int ALPHABET_SIZE = 26,
    parameter int SYM_W         = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             restart,
    input  wire logic [SYM_W-1:0] key [trc_pkg::ROTORS],
    output logic      [SYM_W-1:0] offset [trc_pkg::ROTORS]
);

    import trc_pkg::*;

    logic [SYM_W-1:0]   offset_reg [ROTORS];
    logic [SYM_W-1:0]   base       [ROTORS];
    logic [ROTORS-1:0]  advance;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_base;
    logic [COUNT_W-1:0] count_next;

    assign count_base = restart ? '0 : count_reg;
    assign count_next = (count_base < STEP_FIRST_AT) ? count_base + 1'b1 : count_base;

    assign advance[ROTOR_THIRD]  = (count_base >= STEP_THIRD_AT);
    assign advance[ROTOR_SECOND] = (count_base >= STEP_SECOND_AT);
    assign advance[ROTOR_FIRST]  = (count_base >= STEP_FIRST_AT);

    always_comb
    begin
        for (int r = 0; r < ROTORS; r++)
        begin
            base[r] = restart ? key[r] : offset_reg[r];
            if (!advance[r])
                offset[r] = base[r];
            else if (base[r] == SYM_W'(ALPHABET_SIZE - 1))
                offset[r] = '0;
            else
                offset[r] = base[r] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int r = 0; r < ROTORS; r++)
                offset_reg[r] <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            for (int r = 0; r < ROTORS; r++)
                offset_reg[r] <= offset[r];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= STEP_FIRST_AT)
        else $error("symbol count passed its saturation value");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !restart && count_reg == STEP_FIRST_AT |=> count_reg == STEP_FIRST_AT)
        else $error("saturated symbol count moved without a restart");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(offset_reg[ROTOR_FIRST]) < ALPHABET_SIZE
        && 32'(offset_reg[ROTOR_SECOND]) < ALPHABET_SIZE
        && 32'(offset_reg[ROTOR_THIRD]) < ALPHABET_SIZE)
        else $error("rotor offset outside the alphabet");

endmodule

`default_nettype wire

@@ verif/three_rotor_cipher_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-rotor cipher testbench
// Loads full rotor permutations before any symbol is sent, then runs directed
// beats (field extremes, ignored loads, unknown operation, key reduction,
// counter saturation, broken permutation) and random messages. Both channels
// idle in random bursts. An in-bench cipher model predicts each result, which
// is checked in order against the output channel.
// ----------------------------------------------------------------------------

module three_rotor_cipher_test;

    import trc_pkg::*;

    localparam int ALPHABET     = 26;
    localparam int TABLE_DEPTH  = ROTORS * ALPHABET;
    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_ITEMS  = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SYMBOL_MAX   = SYMBOL_CODES - 1;

    localparam logic [SEL_W-1:0] ROTOR_NONE = 2'd3;
    localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [SEL_W-1:0]    sel;
        logic [SYMBOL_W-1:0] idx;
        logic [SYMBOL_W-1:0] val;
        logic [SYMBOL_W-1:0] sym;
        logic                first;
    } cipher_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      operation = OP_LOAD;
    logic [SEL_W-1:0]     rotor_select = '0;
    logic [SYMBOL_W-1:0]  entry_index = '0;
    logic [SYMBOL_W-1:0]  entry_value = '0;
    logic [SYMBOL_W-1:0]  symbol = '0;
    logic                 first_of_message = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SYMBOL_W-1:0]  result_symbol;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_FIRST;
    logic [KEY_W-1:0]     cfg_data = '0;

    logic [SYMBOL_W-1:0] rotor_fwd [TABLE_DEPTH];
    logic [SYMBOL_W-1:0] rotor_inv [TABLE_DEPTH];
    int unsigned         rotor_offset [ROTORS];
    int unsigned         key_reg [ROTORS];
    int unsigned         symbol_count;
    logic [SYMBOL_W-1:0] expected_symbols [$];
    logic [SYMBOL_W-1:0] wanted_symbol;

    int errors       = 0;
    int items_sent   = 0;
    int idle_cycles  = 0;
    int gap_chance   = 0;
    int stall_chance = 0;
    bit quiet        = 1'b0;

    three_rotor_cipher #(
        .ALPHABET_SIZE(ALPHABET)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .rotor_select(rotor_select),
        .entry_index(entry_index),
        .entry_value(entry_value),
        .symbol(symbol),
        .first_of_message(first_of_message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_symbol(result_symbol),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void cipher_step(input cipher_item_t it);
        int unsigned s;
        int unsigned x;
        if (it.op == OP_LOAD)
        begin
            if (it.sel < ROTORS && it.idx < ALPHABET && it.val < ALPHABET)
            begin
                rotor_fwd[it.sel * ALPHABET + it.idx] = it.val;
                rotor_inv[it.sel * ALPHABET + it.val] = it.idx;
            end
            return;
        end
        if (it.op != OP_ENCRYPT && it.op != OP_DECRYPT)
            return;
        s = it.sym % ALPHABET;
        if (it.first)
        begin
            symbol_count = 0;
            for (int r = 0; r < ROTORS; r++)
                rotor_offset[r] = key_reg[r] % ALPHABET;
        end
        if (symbol_count >= STEP_THIRD_AT)
            rotor_offset[ROTOR_THIRD] = (rotor_offset[ROTOR_THIRD] + 1) % ALPHABET;
        if (symbol_count >= STEP_SECOND_AT)
            rotor_offset[ROTOR_SECOND] = (rotor_offset[ROTOR_SECOND] + 1) % ALPHABET;
        if (symbol_count >= STEP_FIRST_AT)
            rotor_offset[ROTOR_FIRST] = (rotor_offset[ROTOR_FIRST] + 1) % ALPHABET;
        if (symbol_count < STEP_FIRST_AT)
            symbol_count++;
        if (it.op == OP_ENCRYPT)
        begin
            x = 32'(rotor_fwd[ROTOR_THIRD * ALPHABET
                          + (s + ALPHABET - rotor_offset[ROTOR_THIRD]) % ALPHABET]);
            x = 32'(rotor_fwd[ROTOR_SECOND * ALPHABET
                          + (x + ALPHABET - rotor_offset[ROTOR_SECOND]) % ALPHABET]);
            x = 32'(rotor_fwd[ROTOR_FIRST * ALPHABET
                          + (x + ALPHABET - rotor_offset[ROTOR_FIRST]) % ALPHABET]);
        end
        else
        begin
            x = (rotor_inv[ROTOR_FIRST * ALPHABET + s] + rotor_offset[ROTOR_FIRST]) % ALPHABET;
            x = (rotor_inv[ROTOR_SECOND * ALPHABET + x] + rotor_offset[ROTOR_SECOND])
                % ALPHABET;
            x = (rotor_inv[ROTOR_THIRD * ALPHABET + x] + rotor_offset[ROTOR_THIRD])
                % ALPHABET;
        end
        expected_symbols.push_back(x[SYMBOL_W-1:0]);
    endfunction

    // Checks each output beat, feeds each input beat to the model and keeps the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KEY_FIRST:  key_reg[ROTOR_FIRST] = 32'(cfg_data);
                    CFG_KEY_SECOND: key_reg[ROTOR_SECOND] = 32'(cfg_data);
                    CFG_KEY_THIRD:  key_reg[ROTOR_THIRD] = 32'(cfg_data);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $display("%0t: result_symbol expected none, actual %0d",
                             $time, result_symbol);
                    errors++;
                end
                else
                begin
                    wanted_symbol = expected_symbols.pop_front();
                    if (result_symbol !== wanted_symbol)
                    begin
                        $display("%0t: result_symbol expected %0d, actual %0d",
                                 $time, wanted_symbol, result_symbol);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                cipher_step('{operation, rotor_select, entry_index, entry_value,
                              symbol, first_of_message});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!quiet && stall_chance != 0 && $urandom_range(1, stall_chance) == 1)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input cipher_item_t it);
        @(negedge clk);
        if (!quiet && gap_chance != 0 && $urandom_range(1, gap_chance) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= it.op;
        rotor_select     <= it.sel;
        entry_index      <= it.idx;
        entry_value      <= it.val;
        symbol           <= it.sym;
        first_of_message <= it.first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_keys(input logic [KEY_W-1:0] key_first, key_second, key_third);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_KEY_FIRST;
        cfg_data  <= key_first;
        @(negedge clk);
        cfg_index <= CFG_KEY_SECOND;
        cfg_data  <= key_second;
        @(negedge clk);
        cfg_index <= CFG_KEY_THIRD;
        cfg_data  <= key_third;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic cipher_item_t load_item(input logic [SEL_W-1:0] sel,
                                               input logic [SYMBOL_W-1:0] idx, val);
        cipher_item_t it;
        it.op    = OP_LOAD;
        it.sel   = sel;
        it.idx   = idx;
        it.val   = val;
        it.sym   = SYMBOL_W'($urandom);
        it.first = 1'($urandom);
        return it;
    endfunction

    function automatic cipher_item_t symbol_item(input logic [OP_W-1:0] op,
                                                 input logic [SYMBOL_W-1:0] sym,
                                                 input logic first);
        cipher_item_t it;
        it.op    = op;
        it.sel   = SEL_W'($urandom);
        it.idx   = SYMBOL_W'($urandom);
        it.val   = SYMBOL_W'($urandom);
        it.sym   = sym;
        it.first = first;
        return it;
    endfunction

    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        if ($urandom_range(0, 7) == 0)
            return SYMBOL_W'($urandom_range(ALPHABET, SYMBOL_MAX));
        return SYMBOL_W'($urandom_range(0, ALPHABET - 1));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return KEY_W'(ALPHABET - 1);
            2: return KEY_W'(ALPHABET);
            3: return KEY_W'(SYMBOL_MAX);
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 12;
        endcase
    endfunction

    task automatic load_rotor(input int unsigned r);
        logic [SYMBOL_W-1:0] perm [ALPHABET];
        int unsigned order [ALPHABET];
        logic [SYMBOL_W-1:0] swap_val;
        int unsigned swap_pos;
        int unsigned j;
        for (int i = 0; i < ALPHABET; i++)
        begin
            perm[i]  = SYMBOL_W'(i);
            order[i] = i;
        end
        for (int i = ALPHABET - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            swap_val = perm[i];
            perm[i]  = perm[j];
            perm[j]  = swap_val;
            j = $urandom_range(0, i);
            swap_pos = order[i];
            order[i] = order[j];
            order[j] = swap_pos;
        end
        for (int i = 0; i < ALPHABET; i++)
            send_item(load_item(SEL_W'(r), SYMBOL_W'(order[i]), perm[order[i]]));
    endtask

    task automatic send_message(input int unsigned length);
        logic [OP_W-1:0] op;
        bit mixed;
        mixed = ($urandom_range(0, 3) == 0);
        op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
        for (int i = 0; i < length; i++)
        begin
            if (mixed)
                op = $urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT;
            send_item(symbol_item(op, pick_symbol(), i == 0 || $urandom_range(0, 39) == 0));
        end
    endtask

    task automatic test_rotor_loading();
        load_rotor(ROTOR_FIRST);
        load_rotor(ROTOR_SECOND);
        load_rotor(ROTOR_THIRD);
        send_item(load_item(ROTOR_NONE, '0, '0));
        send_item(load_item(SEL_W'(ROTOR_FIRST), SYMBOL_W'(SYMBOL_MAX), '0));
        send_item(load_item(SEL_W'(ROTOR_SECOND), '0, SYMBOL_W'(SYMBOL_MAX)));
        send_item(load_item(SEL_W'(ROTOR_THIRD), SYMBOL_W'(ALPHABET), SYMBOL_W'(1)));
        send_item(symbol_item(OP_UNUSED, SYMBOL_W'(SYMBOL_MAX), 1'b1));
    endtask

    task automatic test_symbol_extremes();
        send_item(symbol_item(OP_ENCRYPT, '0, 1'b1));
        send_item(symbol_item(OP_ENCRYPT, SYMBOL_W'(ALPHABET - 1), 1'b0));
        send_item(symbol_item(OP_ENCRYPT, SYMBOL_W'(SYMBOL_MAX), 1'b0));
        send_item(symbol_item(OP_DECRYPT, '0, 1'b0));
        send_item(symbol_item(OP_DECRYPT, SYMBOL_W'(SYMBOL_MAX), 1'b0));
        send_item(symbol_item(OP_DECRYPT, SYMBOL_W'(ALPHABET - 1), 1'b0));
        repeat (9)
            send_item(symbol_item(OP_ENCRYPT, pick_symbol(), 1'b0));
    endtask

    task automatic test_key_reduction();
        wait_idle();
        write_keys(KEY_W'(SYMBOL_MAX), KEY_W'(ALPHABET), KEY_W'(ALPHABET - 1));
        send_item(symbol_item(OP_ENCRYPT, '0, 1'b1));
        send_item(symbol_item(OP_DECRYPT, SYMBOL_W'(ALPHABET - 1), 1'b1));
        repeat (3)
            send_item(symbol_item(OP_DECRYPT, pick_symbol(), 1'b0));
    endtask

    task automatic test_broken_permutation();
        send_item(load_item(SEL_W'(ROTOR_SECOND), '0,
                            rotor_fwd[ROTOR_SECOND * ALPHABET + 1]));
        send_item(symbol_item(OP_DECRYPT, pick_symbol(), 1'b1));
        send_item(symbol_item(OP_ENCRYPT, pick_symbol(), 1'b0));
        send_item(symbol_item(OP_DECRYPT, pick_symbol(), 1'b0));
        load_rotor(ROTOR_SECOND);
    endtask

    task automatic test_random_traffic();
        cipher_item_t noise;
        while (items_sent < ITEM_TARGET - QUIET_ITEMS)
        begin
            gap_chance   = pick_rate();
            stall_chance = pick_rate();
            case ($urandom_range(0, 9))
                0:
                begin
                    wait_idle();
                    write_keys(pick_key(), pick_key(), pick_key());
                end
                1: load_rotor($urandom_range(ROTOR_FIRST, ROTOR_THIRD));
                2:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        noise = symbol_item(OP_W'($urandom), SYMBOL_W'($urandom),
                                            1'($urandom));
                        send_item(noise);
                    end
                end
                default: send_message($urandom_range(1, 30));
            endcase
        end
    endtask

    task automatic test_quiet_tail();
        quiet        = 1'b1;
        gap_chance   = 0;
        stall_chance = 0;
        while (items_sent < ITEM_TARGET)
            send_message($urandom_range(1, 30));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_chance   = 4;
        stall_chance = 4;
        test_rotor_loading();
        test_symbol_extremes();
        test_key_reduction();
        test_broken_permutation();
        test_random_traffic();
        test_quiet_tail();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_symbols.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_symbols.size() != 0)
        begin
            $display("%0t: %0d results still outstanding", $time, expected_symbols.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ three_rotor_cipher.f @@
hdl/trc_pkg.sv
hdl/trc_rotor.sv
hdl/trc_stepper.sv
hdl/three_rotor_cipher.sv
verif/three_rotor_cipher_test.sv
